FILE: sv/tfa_pkg.sv
// shared widths, field layout and defaults for the triangle face adjacency core
package tfa_pkg;

	localparam int FACE_IDX_W      = 10;
	localparam int VTX_FIELD_W     = 16;
	localparam int FACE_COUNT_W    = 11;
	localparam int NB_COUNT_W      = 2;
	localparam int MAX_NEIGHBOURS  = 3;
	localparam int SHARED_FOR_EDGE = 2;

	localparam int DEF_MAX_FACES   = 1024;
	localparam int DEF_VERTEX_BITS = 16;

	// s_tdata layout
	localparam int IN_IDX_LO  = 0;
	localparam int IN_VA_LO   = IN_IDX_LO + FACE_IDX_W;
	localparam int IN_VB_LO   = IN_VA_LO + VTX_FIELD_W;
	localparam int IN_VC_LO   = IN_VB_LO + VTX_FIELD_W;
	localparam int IN_USED_W  = IN_VC_LO + VTX_FIELD_W;
	localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

	// m_tdata layout
	localparam int OUT_USED_W  = FACE_IDX_W + NB_COUNT_W + MAX_NEIGHBOURS * FACE_IDX_W;
	localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

	// op codes carried in s_tuser
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

endpackage

FILE: sv/tfa_face_mem.sv
// face table: one write port, one read port, registered read data
module tfa_face_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 48
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/tfa_share_count.sv
// counts query vertices found in another face and flags a shared edge
module tfa_share_count
	import tfa_pkg::*;
#(
	parameter int VW = 16
) (
	input  logic [3*VW-1:0] query_face,
	input  logic [3*VW-1:0] other_face,
	output logic            is_edge
);

	logic [VW-1:0] q0, q1, q2, o0, o1, o2;
	logic          hit0, hit1, hit2;
	logic [1:0]    hits;

	assign q0 = query_face[0*VW +: VW];
	assign q1 = query_face[1*VW +: VW];
	assign q2 = query_face[2*VW +: VW];
	assign o0 = other_face[0*VW +: VW];
	assign o1 = other_face[1*VW +: VW];
	assign o2 = other_face[2*VW +: VW];

	// each query vertex counts once however often it appears in the other face
	assign hit0 = (q0 == o0) || (q0 == o1) || (q0 == o2);
	assign hit1 = (q1 == o0) || (q1 == o1) || (q1 == o2);
	assign hit2 = (q2 == o0) || (q2 == o1) || (q2 == o2);

	assign hits    = 2'(hit0) + 2'(hit1) + 2'(hit2);
	assign is_edge = (hits == 2'(SHARED_FOR_EDGE));

endmodule

FILE: sv/triangle_face_adjacency_core.sv
// triangle face adjacency core: face table load and neighbour query scan
//
//  channel   dir  handshake                 payload
//  s_*       in   s_tvalid / s_tready       tuser: op; tdata: face_index, vertex_a/b/c
//  m_*       out  m_tvalid / m_tready       tdata: queried_face, count, neighbour_0..2
//  cfg_*     in   cfg_we (no back-pressure) cfg_data: face_count
//
// a load writes straight into the table and returns no item
// a query in range first fetches the query face, then makes one table read per
// scanned face through the single read port, each read registered by the table;
// the scan stops early once three neighbours are found
// a query out of range goes straight to the result stage
// reset clears the control state and face_count; the table itself is not cleared
// the result register lets a new item enter while the last result waits on m_tready
module triangle_face_adjacency_core
	import tfa_pkg::*;
#(
	parameter int MAX_FACES         = DEF_MAX_FACES,
	parameter int VERTEX_INDEX_BITS = DEF_VERTEX_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// input items
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [IN_TDATA_W-1:0]   s_tdata,   // face_index, vertex_a, vertex_b, vertex_c, zero pad
	input  logic                    s_tuser,   // op
	// result items
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [OUT_TDATA_W-1:0]  m_tdata,   // queried_face, neighbour_count,
	                                           // neighbour_0, neighbour_1, neighbour_2, zero pad
	// face_count register
	input  logic                    cfg_we,
	input  logic [FACE_COUNT_W-1:0] cfg_data
);

	localparam int AW     = $clog2(MAX_FACES);
	localparam int VW     = VERTEX_INDEX_BITS;
	localparam int FW     = 3 * VW;
	localparam int CLOG_N = $clog2(MAX_FACES + 1);
	// wide enough for face_count and for the table depth itself
	localparam int CNT_W  = (FACE_COUNT_W > CLOG_N) ? FACE_COUNT_W : CLOG_N;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_QREAD = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	localparam logic [NB_COUNT_W-1:0] FOUND_FULL = NB_COUNT_W'(MAX_NEIGHBOURS);

	// configuration
	logic [FACE_COUNT_W-1:0] face_count_q;
	logic [CNT_W-1:0]        used;

	// control
	logic [1:0]              state_q;
	logic [CNT_W-1:0]        used_q;
	logic [CNT_W-1:0]        h_q;
	logic [NB_COUNT_W-1:0]   found_q;
	logic [FACE_IDX_W-1:0]   qidx_q;
	logic [FW-1:0]           qface_q;
	logic [FACE_IDX_W-1:0]   nb_q [MAX_NEIGHBOURS];

	// read pipeline stage
	logic                    valid_s1;
	logic [CNT_W-1:0]        h_s1;

	// result register
	logic                    out_valid_q;
	logic [OUT_USED_W-1:0]   out_data_q;

	// input unpack
	logic                    in_op;
	logic [FACE_IDX_W-1:0]   in_idx;
	logic [VTX_FIELD_W-1:0]  in_va, in_vb, in_vc;
	logic                    s_accept;

	// memory ports
	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic [FW-1:0]           mem_wdata;
	logic                    mem_re;
	logic [AW-1:0]           mem_raddr;
	logic [FW-1:0]           mem_rdata;

	logic                    query_in_range;
	logic                    issue;
	logic                    is_edge;
	logic                    take;
	logic                    scan_done;
	logic                    out_load;

	assign in_op    = s_tuser;
	assign in_idx   = s_tdata[IN_IDX_LO +: FACE_IDX_W];
	assign in_va    = s_tdata[IN_VA_LO +: VTX_FIELD_W];
	assign in_vb    = s_tdata[IN_VB_LO +: VTX_FIELD_W];
	assign in_vc    = s_tdata[IN_VC_LO +: VTX_FIELD_W];

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;

	// face count saturates at the table depth
	assign used = (CNT_W'(face_count_q) > CNT_W'(MAX_FACES)) ? CNT_W'(MAX_FACES)
	                                                        : CNT_W'(face_count_q);

	assign query_in_range = (CNT_W'(in_idx) < used);

	// loads write straight through; out-of-table loads are dropped
	assign mem_we    = s_accept && (in_op == OP_LOAD) && (CNT_W'(in_idx) < CNT_W'(MAX_FACES));
	assign mem_waddr = AW'(in_idx);
	assign mem_wdata = {VW'(in_vc), VW'(in_vb), VW'(in_va)};

	// one table read per cycle while faces remain and the neighbour list is open
	assign issue = (state_q == ST_QREAD) ||
	               ((state_q == ST_SCAN) && (h_q < used_q) && (found_q != FOUND_FULL));

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = h_q[AW-1:0];
		if (s_accept && (in_op == OP_QUERY) && query_in_range) begin
			mem_re    = 1'b1;
			mem_raddr = AW'(in_idx);
		end else if (issue) begin
			mem_re = 1'b1;
		end
	end

	tfa_face_mem #(
		.DEPTH (MAX_FACES),
		.AW    (AW),
		.DW    (FW)
	) u_face_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	tfa_share_count #(
		.VW (VW)
	) u_share_count (
		.query_face (qface_q),
		.other_face (mem_rdata),
		.is_edge    (is_edge)
	);

	// a returned face that shares an edge is a neighbour unless it is the query face itself
	assign take = (state_q == ST_SCAN) && valid_s1 && (found_q != FOUND_FULL) &&
	              (h_s1 != CNT_W'(qidx_q)) && is_edge;

	assign scan_done = (found_q == FOUND_FULL) || (!valid_s1 && (h_q == used_q));

	assign out_load = (state_q == ST_FIN) && (!out_valid_q || m_tready);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_count_q <= '0;
		end else if (cfg_we) begin
			face_count_q <= cfg_data;
		end
	end

	// sequencer and scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			h_q      <= '0;
			found_q  <= '0;
			used_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (issue) begin
				h_q <= h_q + CNT_W'(1);
			end
			if (take) begin
				found_q <= found_q + NB_COUNT_W'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (s_accept && (in_op == OP_QUERY)) begin
						h_q     <= '0;
						found_q <= '0;
						used_q  <= used;
						state_q <= query_in_range ? ST_QREAD : ST_FIN;
					end
				end
				ST_QREAD: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// query payload: index, query face, neighbour slots
	always_ff @(posedge clk) begin
		if (s_accept && (in_op == OP_QUERY)) begin
			qidx_q <= in_idx;
			for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
				nb_q[i] <= '0;
			end
		end
		if (state_q == ST_QREAD) begin
			qface_q <= mem_rdata;
		end
		if (take) begin
			nb_q[found_q] <= h_s1[FACE_IDX_W-1:0];
		end
		if (issue) begin
			h_s1 <= h_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {nb_q[2], nb_q[1], nb_q[0], found_q, qidx_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'(out_data_q);

	// a result appears only from the result stage
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_FIN))
		else $error("result raised outside the result stage");

	// an empty result carries zero slots
	a_empty_slots_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[FACE_IDX_W +: NB_COUNT_W] == '0)) |->
		(m_tdata[FACE_IDX_W + NB_COUNT_W +: MAX_NEIGHBOURS * FACE_IDX_W] == '0))
		else $error("empty result with nonzero neighbour slot");

	// scan table reads in flight only during the scan
	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == ST_SCAN))
		else $error("read data pending outside the scan");

	// the scan never runs past the faces in use
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (h_q <= used_q))
		else $error("scan index beyond face count");

endmodule

FILE: tb/sv/tb_top.sv
// self-checking testbench for the triangle face adjacency core
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tfa_pkg::*;

	localparam int WATCHDOG_LIMIT = 8000;
	localparam int SETTLE_CYCLES  = 10;
	localparam int DRAIN_CYCLES   = 20;
	localparam int HOLD_CYCLES    = 500;
	localparam int RANDOM_ITEMS   = 560;
	localparam int DIRECTED_ROWS  = 25;

	typedef logic [FACE_IDX_W-1:0]  face_idx_t;
	typedef logic [VTX_FIELD_W-1:0] vertex_t;

	// same layout as the used bits of m_tdata, queried face in the lowest bits
	typedef struct packed {
		face_idx_t               nb2;
		face_idx_t               nb1;
		face_idx_t               nb0;
		logic [NB_COUNT_W-1:0]   count;
		face_idx_t               face;
	} adjacency_t;

	typedef enum {ROW_CFG, ROW_LOAD, ROW_QUERY, ROW_QUERY_TYPED} row_kind_t;

	// for a cfg row idx carries the face count; cnt/nb* only matter for typed queries
	typedef struct {
		row_kind_t kind;
		int        idx;
		int        va, vb, vc;
		int        cnt, nb0, nb1, nb2;
	} directed_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [IN_TDATA_W-1:0]   s_tdata;   // face_index, vertex_a, vertex_b, vertex_c, zero pad
	logic                    s_tuser;   // op
	logic                    m_tvalid;
	logic                    m_tready;
	logic [OUT_TDATA_W-1:0]  m_tdata;   // queried_face, neighbour_count, neighbour_0..2, zero pad
	logic                    cfg_we;
	logic [FACE_COUNT_W-1:0] cfg_data;

	// local copy of the face table and the face count register
	vertex_t                 mesh_vtx [DEF_MAX_FACES][3];
	logic [FACE_COUNT_W-1:0] face_count_reg;
	adjacency_t              adjacency_expected [$];

	// small vertex pool so that faces share edges often
	vertex_t pool [64];
	int      pool_size;

	bit quiet_sender;
	int hold_requests;
	int mismatches = 0;
	int results_checked = 0;
	int loads_sent = 0;
	int queries_sent = 0;
	int full_results = 0;
	int empty_results = 0;
	int idle_cycles = 0;

	directed_row_t directed_rows [DIRECTED_ROWS];

	triangle_face_adjacency_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// neighbour list of one face, scanning faces in use in ascending order
	function automatic adjacency_t predict_adjacency(input face_idx_t idx);
		adjacency_t r;
		int         used;
		int         found;
		int         common;
		bit         hit;
		r = '0;
		r.face = idx;
		found = 0;
		used = (face_count_reg > DEF_MAX_FACES) ? DEF_MAX_FACES : int'(face_count_reg);
		if (idx < used) begin
			for (int h = 0; h < used && found < MAX_NEIGHBOURS; h++) begin
				if (h != idx) begin
					common = 0;
					// each vertex of the query face counts once, even if repeated elsewhere
					for (int j = 0; j < 3; j++) begin
						hit = 1'b0;
						for (int k = 0; k < 3; k++)
							if (mesh_vtx[idx][j] == mesh_vtx[h][k])
								hit = 1'b1;
						common += hit;
					end
					if (common == SHARED_FOR_EDGE) begin
						case (found)
							0: r.nb0 = face_idx_t'(h);
							1: r.nb1 = face_idx_t'(h);
							default: r.nb2 = face_idx_t'(h);
						endcase
						found++;
					end
				end
			end
		end
		r.count = found[NB_COUNT_W-1:0];
		return r;
	endfunction

	function automatic int sender_gap();
		int pick;
		if (quiet_sender)
			return 0;
		pick = $urandom_range(19);
		if (pick < 11)
			return 0;
		if (pick < 18)
			return $urandom_range(3, 1);
		return $urandom_range(30, 6);
	endfunction

	function automatic vertex_t pick_vertex();
		// now and then a wide value from the upper half, rarely shared
		if ($urandom_range(9) == 0)
			return vertex_t'($urandom_range(16'hFFF0, 16'h8000));
		return pool[$urandom_range(pool_size - 1)];
	endfunction

	function automatic void new_pool(input int size, input int top);
		pool_size = size;
		for (int i = 0; i < size; i++)
			pool[i] = vertex_t'($urandom_range(top));
	endfunction

	function automatic void check_field(input string what, input int want, input int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		end
	endfunction

	// offers one item after a random gap and returns at the edge that accepts it
	task automatic send_item(input logic op, input face_idx_t idx, input vertex_t va, vb, vc,
			input bit typed, input adjacency_t typed_res);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(IN_TDATA_W - IN_USED_W){1'b0}}, vc, vb, va, idx};
		do @(posedge clk); while (!s_tready);
		if (op == OP_LOAD) begin
			mesh_vtx[idx][0] = va;
			mesh_vtx[idx][1] = vb;
			mesh_vtx[idx][2] = vc;
			loads_sent++;
		end else begin
			adjacency_expected.insert(adjacency_expected.size(),
				typed ? typed_res : predict_adjacency(idx));
			queries_sent++;
		end
	endtask

	// stop offering, wait for all results, then let a trailing load finish
	task automatic settle(input int cycles);
		s_tvalid <= 1'b0;
		while (adjacency_expected.size() != 0)
			@(posedge clk);
		repeat (cycles) @(posedge clk);
	endtask

	task automatic write_cfg(input int value);
		settle(SETTLE_CYCLES);
		cfg_we   <= 1'b1;
		cfg_data <= value[FACE_COUNT_W-1:0];
		@(posedge clk);
		face_count_reg = value[FACE_COUNT_W-1:0];
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// result side: compare each accepted item with the oldest prediction
	always @(posedge clk) begin : result_check
		adjacency_t want;
		adjacency_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[OUT_USED_W-1:0];
			if (adjacency_expected.size() == 0) begin
				mismatches++;
				$display("%0t: result for face %0d with no query waiting", $time, got.face);
			end else begin
				want = adjacency_expected.pop_front();
				check_field("queried_face", int'(want.face), int'(got.face));
				check_field("neighbour_count", int'(want.count), int'(got.count));
				check_field("neighbour_0", int'(want.nb0), int'(got.nb0));
				check_field("neighbour_1", int'(want.nb1), int'(got.nb1));
				check_field("neighbour_2", int'(want.nb2), int'(got.nb2));
				check_field("tdata pad", 0, int'(m_tdata[OUT_TDATA_W-1:OUT_USED_W]));
				results_checked++;
				if (want.count == MAX_NEIGHBOURS)
					full_results++;
				if (want.count == 0)
					empty_results++;
			end
		end
	end

	// receiver: random ready runs and stalls, plus long hold-offs on request
	initial begin : receiver
		int run_left;
		int holds_done;
		m_tready = 1'b0;
		run_left = 0;
		holds_done = 0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			@(posedge clk);
			if (hold_requests > holds_done) begin
				holds_done++;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				run_left = 0;
			end else if (run_left == 0) begin
				if ($urandom_range(9) < 6) begin
					m_tready <= 1'b1;
					run_left = ($urandom_range(4) == 0) ? $urandom_range(150, 40)
					                                    : $urandom_range(8, 1);
				end else begin
					m_tready <= 1'b0;
					case ($urandom_range(19))
						0: run_left = $urandom_range(60, 20);
						1, 2, 3, 4: run_left = $urandom_range(12, 4);
						default: run_left = $urandom_range(3, 1);
					endcase
				end
			end else begin
				run_left--;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no item moved for %0d cycles, %0d results still due",
				$time, idle_cycles, adjacency_expected.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		int         n;
		int         steps;
		int         pick;
		int         rand_items;
		int         phase;
		bit         hold_phase;
		adjacency_t want;

		s_tvalid = 1'b0;
		s_tuser = OP_LOAD;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		face_count_reg = '0;
		hold_requests = 0;
		quiet_sender = 1'b0;

		// small hand-built mesh: faces 1, 2 and 4 border face 0, faces 5 and 6 would be
		// a fourth and a fifth
		// face 4 repeats vertex 0, so seen from face 4 face 0 shares three vertices
		directed_rows = '{
			'{ROW_QUERY_TYPED, 0, 'h1234, 'hABCD, 'h0F0F, 0, 0, 0, 0},
			'{ROW_QUERY_TYPED, 1023, 'hFFFF, 'hFFFF, 'hFFFF, 0, 0, 0, 0},
			'{ROW_LOAD, 0, 0, 1, 2, 0, 0, 0, 0},
			'{ROW_LOAD, 1, 1, 2, 3, 0, 0, 0, 0},
			'{ROW_LOAD, 2, 2, 3, 0, 0, 0, 0, 0},
			'{ROW_LOAD, 3, 'hFFFF, 'hFFFF, 'hFFFF, 0, 0, 0, 0},
			'{ROW_LOAD, 4, 0, 0, 1, 0, 0, 0, 0},
			'{ROW_LOAD, 5, 1, 2, 'hFFFF, 0, 0, 0, 0},
			'{ROW_LOAD, 6, 2, 0, 5, 0, 0, 0, 0},
			'{ROW_LOAD, 1023, 'hFFFF, 0, 'h8000, 0, 0, 0, 0},
			'{ROW_CFG, 7, 0, 0, 0, 0, 0, 0, 0},
			'{ROW_QUERY_TYPED, 0, 'h5555, 'hAAAA, 'h0001, 3, 1, 2, 4},
			'{ROW_QUERY, 4, 'hFFFF, 0, 'hFFFF, 0, 0, 0, 0},
			'{ROW_QUERY, 3, 0, 'hFFFF, 0, 0, 0, 0, 0},
			'{ROW_QUERY, 6, 'h0F0F, 'hF0F0, 'h3C3C, 0, 0, 0, 0},
			'{ROW_QUERY_TYPED, 7, 0, 0, 0, 0, 0, 0, 0},
			'{ROW_QUERY_TYPED, 1023, 0, 0, 0, 0, 0, 0, 0},
			'{ROW_LOAD, 1023, 'hAAAA, 'h5555, 'h00FF, 0, 0, 0, 0},
			'{ROW_CFG, 1, 0, 0, 0, 0, 0, 0, 0},
			'{ROW_QUERY_TYPED, 0, 0, 0, 0, 0, 0, 0, 0},
			'{ROW_QUERY_TYPED, 1, 0, 0, 0, 0, 0, 0, 0},
			'{ROW_CFG, 2, 0, 0, 0, 0, 0, 0, 0},
			'{ROW_QUERY, 1, 0, 0, 0, 0, 0, 0, 0},
			'{ROW_CFG, 0, 0, 0, 0, 0, 0, 0, 0},
			'{ROW_QUERY_TYPED, 0, 0, 0, 0, 0, 0, 0, 0}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			case (directed_rows[r].kind)
				ROW_CFG: write_cfg(directed_rows[r].idx);
				ROW_LOAD: send_item(OP_LOAD, face_idx_t'(directed_rows[r].idx),
					vertex_t'(directed_rows[r].va), vertex_t'(directed_rows[r].vb),
					vertex_t'(directed_rows[r].vc), 1'b0, '0);
				ROW_QUERY: send_item(OP_QUERY, face_idx_t'(directed_rows[r].idx),
					vertex_t'(directed_rows[r].va), vertex_t'(directed_rows[r].vb),
					vertex_t'(directed_rows[r].vc), 1'b0, '0);
				default: begin
					want = '0;
					want.face  = face_idx_t'(directed_rows[r].idx);
					want.count = NB_COUNT_W'(directed_rows[r].cnt);
					want.nb0   = face_idx_t'(directed_rows[r].nb0);
					want.nb1   = face_idx_t'(directed_rows[r].nb1);
					want.nb2   = face_idx_t'(directed_rows[r].nb2);
					send_item(OP_QUERY, face_idx_t'(directed_rows[r].idx),
						vertex_t'(directed_rows[r].va), vertex_t'(directed_rows[r].vb),
						vertex_t'(directed_rows[r].vc), 1'b1, want);
				end
			endcase
		end

		// random meshes: load every face in use, with out-of-range queries mixed in, then mostly in-range queries
		rand_items = 0;
		phase = 0;
		while (rand_items < RANDOM_ITEMS) begin
			hold_phase = (phase == 2 || phase == 12);
			pick = $urandom_range(9);
			if (hold_phase)
				n = 30;
			else if (pick == 0)
				n = $urandom_range(1);
			else if (pick <= 7)
				n = $urandom_range(24, 2);
			else
				n = $urandom_range(64, 25);
			write_cfg(n);
			quiet_sender = hold_phase || ($urandom_range(4) == 0);
			new_pool($urandom_range(4 + n / 4, 3), 16'hFFFF);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(6) == 0) begin
					send_item(OP_QUERY, face_idx_t'($urandom_range(DEF_MAX_FACES - 1, n)),
						vertex_t'($urandom), vertex_t'($urandom), vertex_t'($urandom),
						1'b0, '0);
					rand_items++;
				end
				send_item(OP_LOAD, face_idx_t'(i), pick_vertex(), pick_vertex(), pick_vertex(),
					1'b0, '0);
				rand_items++;
			end
			// receiver holds off while queries keep coming, so the core backs up
			if (hold_phase)
				hold_requests <= hold_requests + 1;
			steps = hold_phase ? 12 : $urandom_range(14, 5);
			repeat (steps) begin
				pick = hold_phase ? 0 : $urandom_range(19);
				if (n > 0 && pick < 13)
					send_item(OP_QUERY, face_idx_t'($urandom_range(n - 1)),
						vertex_t'($urandom), vertex_t'($urandom), vertex_t'($urandom),
						1'b0, '0);
				else if (pick < 16 || n == 0)
					send_item(OP_QUERY, face_idx_t'($urandom_range(DEF_MAX_FACES - 1, n)),
						vertex_t'($urandom), vertex_t'($urandom), vertex_t'($urandom),
						1'b0, '0);
				else if (pick < 18)
					send_item(OP_LOAD, face_idx_t'($urandom_range(n - 1)),
						pick_vertex(), pick_vertex(), pick_vertex(), 1'b0, '0);
				else
					send_item(OP_LOAD, face_idx_t'($urandom_range(DEF_MAX_FACES - 1)),
						pick_vertex(), pick_vertex(), pick_vertex(), 1'b0, '0);
				rand_items++;
			end
			phase++;
		end

		settle(DRAIN_CYCLES);

		$display("covered %0d loads and %0d queries over a hand-built mesh and random meshes,",
			loads_sent, queries_sent);
		$display("%0d results checked: %0d with three neighbours, %0d with none",
			results_checked, full_results, empty_results);
		if (mismatches == 0 && adjacency_expected.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

FILE: sim.f
sv/tfa_pkg.sv
sv/tfa_face_mem.sv
sv/tfa_share_count.sv
sv/triangle_face_adjacency_core.sv
tb/sv/tb_top.sv
